// ===== rtl/aligned_best_fit_pool_allocator_defines.svh =====
// assertion helpers for the pool allocator
`ifndef ALIGNED_BEST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`define ALIGNED_BEST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ABFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abfp check failed");
// next-cycle implication
`define ABFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abfp check failed");
`else
`define ABFP_ASSERT_NOW(lbl, ante, cons)
`define ABFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/abfp_pkg.sv =====
`timescale 1ns / 1ps
package abfp_pkg;
  localparam int FL_DEPTH = 32;
  localparam int FL_IW = $clog2(FL_DEPTH);
  localparam int FL_CW = FL_IW + 1;
  localparam int AT_DEPTH = 64;
  localparam int AT_AW = $clog2(AT_DEPTH);
  localparam int OFF_W = 24;
  localparam int SIZE_W = 25;
  localparam int ALN_W = 26;
  localparam logic [SIZE_W-1:0] POOL_RESET = 25'd4194304;
  localparam logic [SIZE_W-1:0] POOL_MIN = 25'd2048;
  localparam logic [SIZE_W-1:0] POOL_MAX = 25'd16777216;
  localparam logic [ALN_W-1:0] SMALL_MASK = 26'd127;
  localparam logic [ALN_W-1:0] LARGE_MASK = 26'd2047;
  localparam logic [ALN_W-1:0] LARGE_THR = 26'd2048;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK, ST_ZERO, ST_EXCEED, ST_NOFIT, ST_UNKNOWN, ST_MISMATCH, ST_OVERLAP, ST_FULL
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TAIL_CUT, OP_BF_INIT, OP_BF_STEP, OP_BF_SEL, OP_HEAD_CUT,
    OP_SHDN, OP_DEC, OP_ASCAN, OP_FS_INIT, OP_FSCAN, OP_MERGE2, OP_MPREV, OP_MNEXT,
    OP_INS_INIT, OP_SHUP, OP_INSERT, OP_COMMIT_ALLOC, OP_COMMIT_FREE, OP_FINISH
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_BF_SCAN, S_BF_SEL, S_BF_CUT, S_SHDN, S_ASCAN, S_ALEN,
    S_FSCAN, S_FCHK, S_SHUP, S_COMMIT, S_FIN
  } state_e;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [OFF_W-1:0]  result_offset;
    logic [SIZE_W-1:0] aligned_size;
    logic [1:0]        merges;
    logic [5:0]        free_block_count;
    logic [SIZE_W-1:0] used_bytes;
  } res_t;

  typedef struct packed {
    op_e     op;
    status_e code;
  } ctrl_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic too_big;
    logic table_full;
    logic is_small;
    logic list_empty;
    logic tail_fits;
    logic bf_exact;
    logic bf_last;
    logic bf_found;
    logic cut_empty;
    logic shdn_done;
    logic a_hit;
    logic a_end;
    logic len_bad;
    logic fs_stop;
    logic overlap;
    logic mnext;
    logic mprev;
    logic list_full;
    logic ins_done;
  } stat_t;
endpackage

// ===== rtl/abfp_ram.sv =====
`timescale 1ns / 1ps
module abfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/abfp_dp.sv =====
`timescale 1ns / 1ps
module abfp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [abfp_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  abfp_pkg::req_t                      req_i,
  input  abfp_pkg::ctrl_t                     ctrl_i,
  output abfp_pkg::stat_t                     stat_o,
  output abfp_pkg::res_t                      res_o,
  output logic                                done_o
);
  import abfp_pkg::*;

  logic [OFF_W-1:0]  fl_start_q [FL_DEPTH];
  logic [SIZE_W-1:0] fl_len_q [FL_DEPTH];
  logic [FL_CW-1:0]  count_q, count_d;
  logic [FL_CW-1:0]  ptr_q, ptr_d;
  logic [FL_CW-1:0]  best_q, ins_q;
  logic [SIZE_W-1:0] best_len_q;
  logic              found_q;
  logic [SIZE_W-1:0] pool_q, pool_clamp;
  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q, where_q;
  logic [ALN_W-1:0]  aligned_q, aligned_in, round_mask;
  logic [AT_AW-1:0]  sc_q, pend_addr_q, slot_q, free_slot;
  logic              pend_q;
  logic [SIZE_W-1:0] alen_q;
  logic [OFF_W-1:0]  prev_start_q;
  logic [SIZE_W-1:0] prev_len_q, prev_end;
  logic              has_prev_q;
  logic [1:0]        merges_q;
  logic [AT_DEPTH-1:0] valid_q;
  logic [SIZE_W-1:0] used_q;
  res_t              res_q;
  logic              done_q;
  logic [FL_IW-1:0]  rd_idx, wr_idx;
  logic [FL_CW-1:0]  rd_ptr;
  logic [OFF_W-1:0]  rd_start, wr_start;
  logic [SIZE_W-1:0] rd_len, wr_len;
  logic              wr_en, has_cur, bf_take;
  logic [ALN_W-1:0]  off_end;
  logic [OFF_W+SIZE_W-1:0] ram_wdata, ram_rdata;
  logic [OFF_W-1:0]  ram_rstart;

  // request rounding
  always_comb begin
    round_mask = ({1'b0, req_i.size_bytes} >= LARGE_THR) ? LARGE_MASK : SMALL_MASK;
    aligned_in = ({1'b0, req_i.size_bytes} + round_mask) & ~round_mask;
  end

  // pool size clamp
  always_comb begin
    pool_clamp = cfg_wdata_i;
    if (cfg_wdata_i < POOL_MIN) begin
      pool_clamp = POOL_MIN;
    end else if (cfg_wdata_i > POOL_MAX) begin
      pool_clamp = POOL_MAX;
    end
  end

  // free list read port
  always_comb begin
    unique case (ctrl_i.op)
      OP_SHDN: rd_ptr = ptr_q + 1'b1;
      OP_SHUP: rd_ptr = ptr_q - 1'b1;
      default: rd_ptr = ptr_q;
    endcase
    rd_idx   = rd_ptr[FL_IW-1:0];
    rd_start = fl_start_q[rd_idx];
    rd_len   = fl_len_q[rd_idx];
    prev_end = {1'b0, prev_start_q} + prev_len_q;
    off_end  = {2'b0, off_q} + aligned_q;
    has_cur  = ptr_q < count_q;
  end

  // lowest free allocation slot
  always_comb begin
    free_slot = '0;
    for (int i = AT_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = AT_AW'(i);
      end
    end
  end

  assign ram_rstart = ram_rdata[OFF_W+SIZE_W-1:SIZE_W];
  assign bf_take = ({1'b0, rd_len} >= aligned_q) && (!found_q || rd_len < best_len_q);

  // status toward the controller
  always_comb begin
    stat_o.is_free    = (cmd_q == CMD_FREE);
    stat_o.size_zero  = (size_q == '0);
    stat_o.too_big    = aligned_q > {1'b0, pool_q};
    stat_o.table_full = &valid_q;
    stat_o.is_small   = aligned_q < LARGE_THR;
    stat_o.list_empty = (count_q == '0);
    stat_o.tail_fits  = {1'b0, rd_len} >= aligned_q;
    stat_o.bf_exact   = bf_take && ({1'b0, rd_len} == aligned_q);
    stat_o.bf_last    = (ptr_q + 1'b1) == count_q;
    stat_o.bf_found   = found_q;
    stat_o.cut_empty  = {1'b0, rd_len} == aligned_q;
    stat_o.shdn_done  = (ptr_q + 1'b1) >= count_q;
    stat_o.a_hit      = pend_q && valid_q[pend_addr_q] && (ram_rstart == off_q);
    stat_o.a_end      = pend_q && (pend_addr_q == AT_AW'(AT_DEPTH - 1));
    stat_o.len_bad    = {1'b0, alen_q} != aligned_q;
    stat_o.fs_stop    = (ptr_q == count_q) || (rd_start >= off_q);
    stat_o.overlap    = (has_cur && ((rd_start == off_q) || (off_end > {2'b0, rd_start})))
                        || (has_prev_q && (prev_end > {1'b0, off_q}));
    stat_o.mnext      = has_cur && (off_end == {2'b0, rd_start});
    stat_o.mprev      = has_prev_q && (prev_end == {1'b0, off_q});
    stat_o.list_full  = count_q >= FL_CW'(FL_DEPTH);
    stat_o.ins_done   = ptr_q == ins_q;
  end

  // free list write port
  always_comb begin
    wr_en    = 1'b1;
    wr_idx   = ptr_q[FL_IW-1:0];
    wr_start = rd_start;
    wr_len   = rd_len;
    unique case (ctrl_i.op)
      OP_TAIL_CUT: wr_len = rd_len - aligned_q[SIZE_W-1:0];
      OP_HEAD_CUT: begin
        wr_start = rd_start + aligned_q[OFF_W-1:0];
        wr_len   = rd_len - aligned_q[SIZE_W-1:0];
      end
      OP_SHDN, OP_SHUP: ;
      OP_MERGE2: begin
        wr_idx   = FL_IW'(ptr_q - 1'b1);
        wr_start = prev_start_q;
        wr_len   = prev_len_q + aligned_q[SIZE_W-1:0] + rd_len;
      end
      OP_MPREV: begin
        wr_idx   = FL_IW'(ptr_q - 1'b1);
        wr_start = prev_start_q;
        wr_len   = prev_len_q + aligned_q[SIZE_W-1:0];
      end
      OP_MNEXT: begin
        wr_start = off_q;
        wr_len   = rd_len + aligned_q[SIZE_W-1:0];
      end
      OP_INSERT: begin
        wr_start = off_q;
        wr_len   = aligned_q[SIZE_W-1:0];
      end
      default: wr_en = 1'b0;
    endcase
  end

  // free list storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FL_DEPTH; i++) begin
        fl_start_q[i] <= '0;
        fl_len_q[i]   <= '0;
      end
      fl_len_q[0] <= POOL_RESET;
    end else if (cfg_we_i) begin
      fl_start_q[0] <= '0;
      fl_len_q[0]   <= pool_clamp;
    end else if (wr_en) begin
      fl_start_q[wr_idx] <= wr_start;
      fl_len_q[wr_idx]   <= wr_len;
    end
  end

  // list count and pointer
  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    unique case (ctrl_i.op)
      OP_LOAD: ptr_d = count_q - 1'b1;
      OP_TAIL_CUT: if ({1'b0, rd_len} == aligned_q) count_d = count_q - 1'b1;
      OP_DEC: count_d = count_q - 1'b1;
      OP_INSERT: count_d = count_q + 1'b1;
      OP_BF_INIT, OP_FS_INIT: ptr_d = '0;
      OP_BF_STEP, OP_SHDN, OP_FSCAN: ptr_d = ptr_q + 1'b1;
      OP_BF_SEL: ptr_d = best_q;
      OP_INS_INIT: ptr_d = count_q;
      OP_SHUP: ptr_d = ptr_q - 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= FL_CW'(1);
      ptr_q    <= '0;
      pool_q   <= POOL_RESET;
      valid_q  <= '0;
      used_q   <= '0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      has_prev_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= (ctrl_i.op == OP_FINISH);
      if (cfg_we_i) begin
        count_q <= FL_CW'(1);
        pool_q  <= pool_clamp;
        valid_q <= '0;
        used_q  <= '0;
      end else begin
        count_q <= count_d;
        if (ctrl_i.op == OP_COMMIT_ALLOC) begin
          valid_q[free_slot] <= 1'b1;
          used_q <= used_q + aligned_q[SIZE_W-1:0];
        end else if (ctrl_i.op == OP_COMMIT_FREE) begin
          valid_q[slot_q] <= 1'b0;
          used_q <= used_q - aligned_q[SIZE_W-1:0];
        end
      end
      ptr_q <= ptr_d;
      unique case (ctrl_i.op)
        OP_LOAD: begin
          pend_q     <= 1'b0;
          found_q    <= 1'b0;
          has_prev_q <= 1'b0;
        end
        OP_BF_INIT: found_q <= 1'b0;
        OP_BF_STEP: if (bf_take) found_q <= 1'b1;
        OP_ASCAN: pend_q <= 1'b1;
        OP_FS_INIT: has_prev_q <= 1'b0;
        OP_FSCAN: has_prev_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // request payload and scratch registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        cmd_q     <= req_i.command;
        size_q    <= req_i.size_bytes;
        off_q     <= req_i.block_offset;
        aligned_q <= (req_i.size_bytes == '0) ? '0 : aligned_in;
        where_q   <= '0;
        merges_q  <= 2'd0;
        sc_q      <= '0;
      end
      OP_TAIL_CUT: where_q <= OFF_W'({1'b0, rd_start} + rd_len - aligned_q[SIZE_W-1:0]);
      OP_HEAD_CUT: where_q <= rd_start;
      OP_BF_STEP: begin
        if (bf_take) begin
          best_q     <= ptr_q;
          best_len_q <= rd_len;
        end
      end
      OP_ASCAN: begin
        sc_q        <= sc_q + 1'b1;
        pend_addr_q <= sc_q;
        if (stat_o.a_hit) begin
          slot_q <= pend_addr_q;
          alen_q <= ram_rdata[SIZE_W-1:0];
        end
      end
      OP_FSCAN: begin
        prev_start_q <= rd_start;
        prev_len_q   <= rd_len;
      end
      OP_MERGE2: merges_q <= 2'd2;
      OP_MPREV, OP_MNEXT: merges_q <= 2'd1;
      OP_INS_INIT: ins_q <= ptr_q;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_FINISH) begin
      res_q.status <= ctrl_i.code;
      if (cmd_q == CMD_FREE) begin
        res_q.result_offset <= off_q;
      end else begin
        res_q.result_offset <= (ctrl_i.code == ST_OK) ? where_q : '0;
      end
      res_q.aligned_size     <= aligned_q[ALN_W-1] ? '1 : aligned_q[SIZE_W-1:0];
      res_q.merges           <= (ctrl_i.code == ST_OK) ? merges_q : 2'd0;
      res_q.free_block_count <= 6'(count_q);
      res_q.used_bytes       <= used_q;
    end
  end

  assign ram_wdata = {where_q, aligned_q[SIZE_W-1:0]};

  // allocation table
  abfp_ram #(
    .WIDTH(OFF_W + SIZE_W),
    .DEPTH(AT_DEPTH)
  ) u_at_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == OP_COMMIT_ALLOC),
    .waddr_i (free_slot),
    .wdata_i (ram_wdata),
    .raddr_i (sc_q),
    .rdata_o (ram_rdata)
  );

  assign res_o  = res_q;
  assign done_o = done_q;
endmodule

// ===== rtl/abfp_ctrl.sv =====
`timescale 1ns / 1ps
module abfp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  abfp_pkg::stat_t stat_i,
  output abfp_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import abfp_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.is_free) begin
          state_d = stat_i.size_zero ? S_IDLE : S_ASCAN;
        end else if (stat_i.size_zero || stat_i.too_big || stat_i.table_full) begin
          state_d = S_IDLE;
        end else if (stat_i.is_small && !stat_i.list_empty && stat_i.tail_fits) begin
          state_d = S_COMMIT;
        end else if (stat_i.list_empty) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_BF_SCAN;
        end
      end
      S_BF_SCAN: if (stat_i.bf_exact || stat_i.bf_last) state_d = S_BF_SEL;
      S_BF_SEL: state_d = stat_i.bf_found ? S_BF_CUT : S_IDLE;
      S_BF_CUT: state_d = stat_i.cut_empty ? S_SHDN : S_COMMIT;
      S_SHDN: if (stat_i.shdn_done) state_d = S_COMMIT;
      S_ASCAN: begin
        if (stat_i.a_hit) begin
          state_d = S_ALEN;
        end else if (stat_i.a_end) begin
          state_d = S_IDLE;
        end
      end
      S_ALEN: state_d = stat_i.len_bad ? S_IDLE : S_FSCAN;
      S_FSCAN: if (stat_i.fs_stop) state_d = S_FCHK;
      S_FCHK: begin
        priority if (stat_i.overlap) begin
          state_d = S_IDLE;
        end else if (stat_i.mnext && stat_i.mprev) begin
          state_d = S_SHDN;
        end else if (stat_i.mprev || stat_i.mnext) begin
          state_d = S_COMMIT;
        end else if (stat_i.list_full) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SHUP;
        end
      end
      S_SHUP: if (stat_i.ins_done) state_d = S_COMMIT;
      S_COMMIT: state_d = S_FIN;
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctrl_o.op   = OP_NONE;
    ctrl_o.code = ST_OK;
    unique case (state_q)
      S_IDLE: if (start_i) ctrl_o.op = OP_LOAD;
      S_CHECK: begin
        if (stat_i.is_free) begin
          if (stat_i.size_zero) begin
            ctrl_o.op   = OP_FINISH;
            ctrl_o.code = ST_ZERO;
          end
        end else if (stat_i.size_zero) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_ZERO;
        end else if (stat_i.too_big) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_EXCEED;
        end else if (stat_i.table_full) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_FULL;
        end else if (stat_i.is_small && !stat_i.list_empty && stat_i.tail_fits) begin
          ctrl_o.op = OP_TAIL_CUT;
        end else if (stat_i.list_empty) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_NOFIT;
        end else begin
          ctrl_o.op = OP_BF_INIT;
        end
      end
      S_BF_SCAN: ctrl_o.op = OP_BF_STEP;
      S_BF_SEL: begin
        if (stat_i.bf_found) begin
          ctrl_o.op = OP_BF_SEL;
        end else begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_NOFIT;
        end
      end
      S_BF_CUT: ctrl_o.op = OP_HEAD_CUT;
      S_SHDN: ctrl_o.op = stat_i.shdn_done ? OP_DEC : OP_SHDN;
      S_ASCAN: begin
        if (!stat_i.a_hit && stat_i.a_end) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_UNKNOWN;
        end else begin
          ctrl_o.op = OP_ASCAN;
        end
      end
      S_ALEN: begin
        if (stat_i.len_bad) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_MISMATCH;
        end else begin
          ctrl_o.op = OP_FS_INIT;
        end
      end
      S_FSCAN: if (!stat_i.fs_stop) ctrl_o.op = OP_FSCAN;
      S_FCHK: begin
        priority if (stat_i.overlap) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_OVERLAP;
        end else if (stat_i.mnext && stat_i.mprev) begin
          ctrl_o.op = OP_MERGE2;
        end else if (stat_i.mprev) begin
          ctrl_o.op = OP_MPREV;
        end else if (stat_i.mnext) begin
          ctrl_o.op = OP_MNEXT;
        end else if (stat_i.list_full) begin
          ctrl_o.op   = OP_FINISH;
          ctrl_o.code = ST_FULL;
        end else begin
          ctrl_o.op = OP_INS_INIT;
        end
      end
      S_SHUP: ctrl_o.op = stat_i.ins_done ? OP_INSERT : OP_SHUP;
      S_COMMIT: ctrl_o.op = stat_i.is_free ? OP_COMMIT_FREE : OP_COMMIT_ALLOC;
      S_FIN: ctrl_o.op = OP_FINISH;
      default: ctrl_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

// ===== rtl/aligned_best_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
// an error found on entry ends the request there; a small allocate is cut from the top
// block when it fits there, any other allocate takes a best-fit scan of the free list, and
// a free walks the allocation table one slot a cycle through the RAM read port
// throughput: one request at a time, the next accepted once busy drops
// reset and pool size writes rebuild the store at once; results cannot be stalled
`include "aligned_best_fit_pool_allocator_defines.svh"
module aligned_best_fit_pool_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  abfp_pkg::req_t               req_i,
  input  logic                         cfg_we_i,
  input  logic [abfp_pkg::SIZE_W-1:0]  cfg_wdata_i,
  output abfp_pkg::res_t               res_o,
  output logic                         done_o
);
  import abfp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  abfp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // free list, allocation table and result
  abfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_o       (res_o),
    .done_o      (done_o)
  );

  // checks
  `ABFP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ABFP_ASSERT_NEXT(a_done_pulse, done_o, !done_o)
  `ABFP_ASSERT_NOW(a_err_no_merge, done_o && (res_o.status != ST_OK), res_o.merges == 2'd0)
  `ABFP_ASSERT_NOW(a_done_idle, done_o, !busy)
endmodule

// ===== sim/tb_aligned_best_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
module tb_aligned_best_fit_pool_allocator;
  import abfp_pkg::*;

  localparam int SETTLE_CYCLES = 200;

  // pool model: free list, allocation table, expected results
  class alloc_scoreboard;
    longint pool;
    longint fstart[FL_DEPTH];
    longint flen[FL_DEPTH];
    int     fcount;
    longint astart[AT_DEPTH];
    longint alen[AT_DEPTH];
    bit     avalid[AT_DEPTH];
    longint used;
    res_t   expected_q[$];
    int     errors;
    int     results;
    int     ok_count;
    int     status_seen[8];

    function new();
      pool = POOL_RESET;
      rebuild();
    endfunction

    function void rebuild();
      for (int k = 0; k < AT_DEPTH; k++) avalid[k] = 0;
      fstart[0] = 0;
      flen[0] = pool;
      fcount = 1;
      used = 0;
    endfunction

    function void set_pool(logic [SIZE_W-1:0] v);
      longint p;
      p = v;
      if (p < POOL_MIN) p = POOL_MIN;
      if (p > POOL_MAX) p = POOL_MAX;
      pool = p;
      rebuild();
    endfunction

    function void drop_entry(int i);
      for (int k = i; k + 1 < fcount; k++) begin
        fstart[k] = fstart[k+1];
        flen[k] = flen[k+1];
      end
      fcount--;
    endfunction

    function status_e carve(longint aligned, output longint where);
      int  slot;
      int  best;
      bit  found;
      bit  placed;
      int  last;
      slot = AT_DEPTH;
      best = 0;
      found = 0;
      placed = 0;
      where = 0;
      for (int s = AT_DEPTH - 1; s >= 0; s--) if (!avalid[s]) slot = s;
      if (slot >= AT_DEPTH) return ST_FULL;
      // small request: tail of the top block
      if (aligned < LARGE_THR && fcount > 0) begin
        last = fcount - 1;
        if (flen[last] >= aligned) begin
          where = fstart[last] + flen[last] - aligned;
          flen[last] -= aligned;
          if (flen[last] == 0) drop_entry(last);
          placed = 1;
        end
      end
      // best fit, lowest address on ties
      if (!placed) begin
        for (int i = 0; i < fcount; i++) begin
          if (flen[i] >= aligned && (!found || flen[i] < flen[best])) begin
            best = i;
            found = 1;
            if (flen[i] == aligned) break;
          end
        end
        if (!found) return ST_NOFIT;
        where = fstart[best];
        fstart[best] += aligned;
        flen[best] -= aligned;
        if (flen[best] == 0) drop_entry(best);
      end
      avalid[slot] = 1;
      astart[slot] = where & 64'hFFFFFF;
      alen[slot] = aligned;
      used += aligned;
      return ST_OK;
    endfunction

    function status_e release_block(longint off, longint aligned, output int merges);
      int slot;
      int i;
      bit mn;
      bit mp;
      slot = AT_DEPTH;
      merges = 0;
      for (int s = AT_DEPTH - 1; s >= 0; s--) if (avalid[s] && astart[s] == off) slot = s;
      if (slot >= AT_DEPTH) return ST_UNKNOWN;
      if (alen[slot] != aligned) return ST_MISMATCH;
      i = fcount;
      for (int k = fcount - 1; k >= 0; k--) if (fstart[k] >= off) i = k;
      if (i < fcount && (fstart[i] == off || off + aligned > fstart[i])) return ST_OVERLAP;
      if (i > 0 && fstart[i-1] + flen[i-1] > off) return ST_OVERLAP;
      mn = (i < fcount) && (off + aligned == fstart[i]);
      mp = (i > 0) && (fstart[i-1] + flen[i-1] == off);
      if (!mn && !mp && fcount >= FL_DEPTH) return ST_FULL;
      if (mn && mp) begin
        flen[i-1] += aligned + flen[i];
        drop_entry(i);
        merges = 2;
      end else if (mp) begin
        flen[i-1] += aligned;
        merges = 1;
      end else if (mn) begin
        fstart[i] = off;
        flen[i] += aligned;
        merges = 1;
      end else begin
        for (int k = fcount; k > i; k--) begin
          fstart[k] = fstart[k-1];
          flen[k] = flen[k-1];
        end
        fstart[i] = off;
        flen[i] = aligned;
        fcount++;
      end
      avalid[slot] = 0;
      used -= aligned;
      return ST_OK;
    endfunction

    // accepted request: work out its result
    function void note(req_t r);
      longint  size;
      longint  aligned;
      longint  where;
      longint  grain;
      status_e st;
      int      merges;
      res_t    e;
      size = r.size_bytes;
      aligned = 0;
      where = 0;
      merges = 0;
      if (size != 0) begin
        grain = (size >= LARGE_THR) ? 2048 : 128;
        aligned = (size + grain - 1) / grain * grain;
      end
      if (r.command == CMD_ALLOC) begin
        if (size == 0) st = ST_ZERO;
        else if (aligned > pool) st = ST_EXCEED;
        else st = carve(aligned, where);
        if (st != ST_OK) where = 0;
      end else begin
        where = r.block_offset;
        if (size == 0) st = ST_ZERO;
        else st = release_block(where, aligned, merges);
        if (st != ST_OK) merges = 0;
      end
      e.status = st;
      e.result_offset = where[OFF_W-1:0];
      e.aligned_size = (aligned > 64'h1FFFFFF) ? 25'h1FFFFFF : aligned[SIZE_W-1:0];
      e.merges = merges[1:0];
      e.free_block_count = fcount[5:0];
      e.used_bytes = used[SIZE_W-1:0];
      expected_q.insert(expected_q.size(), e);
    endfunction

    // result from the block against the oldest expectation
    function void check(res_t a);
      res_t e;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      status_seen[e.status]++;
      if (e.status == ST_OK) ok_count++;
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.result_offset !== e.result_offset) begin
        $error("result_offset exp %0h got %0h", e.result_offset, a.result_offset); errors++;
      end
      if (a.aligned_size !== e.aligned_size) begin
        $error("aligned_size exp %0h got %0h", e.aligned_size, a.aligned_size); errors++;
      end
      if (a.merges !== e.merges) begin
        $error("merges exp %0d got %0d", e.merges, a.merges); errors++;
      end
      if (a.free_block_count !== e.free_block_count) begin
        $error("free_block_count exp %0d got %0d", e.free_block_count, a.free_block_count);
        errors++;
      end
      if (a.used_bytes !== e.used_bytes) begin
        $error("used_bytes exp %0h got %0h", e.used_bytes, a.used_bytes); errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  req_t               req_i;
  logic               cfg_we_i;
  logic [SIZE_W-1:0]  cfg_wdata_i;
  res_t               res_o;
  logic               done_o;

  alloc_scoreboard sb;
  int     burst_left;
  longint last_freed;
  int     alloc_pct;
  int     sent;

  aligned_best_fit_pool_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .res_o(res_o), .done_o(done_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // request and result monitors
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note(req_i);
    if (rst_ni && done_o) sb.check(res_o);
  end

  // hold start until the block takes the request
  task automatic send(req_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic send_op(logic cmd, longint size, longint off);
    req_t r;
    r.command = cmd;
    r.size_bytes = size[SIZE_W-1:0];
    r.block_offset = off[OFF_W-1:0];
    send(r);
  endtask

  // drain outstanding requests, let the block settle
  task automatic quiesce();
    start <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [SIZE_W-1:0] v);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_pool(v);
  endtask

  // pick a live block, or -1
  function automatic int live_slot();
    int picks[$];
    for (int s = 0; s < AT_DEPTH; s++) if (sb.avalid[s]) picks.insert(picks.size(), s);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  // size that rounds back to len
  function automatic longint size_for(longint len);
    longint s;
    if (len < 2048) s = len - $urandom_range(0, 127);
    else begin
      s = len - $urandom_range(0, 2047);
      if (s < 2048) s = 2048;
    end
    return s;
  endfunction

  task automatic random_request();
    int     r;
    int     s;
    longint sz;
    r = $urandom_range(0, 99);
    s = live_slot();
    if (r < alloc_pct) begin
      case ($urandom_range(0, 9))
        0:       sz = $urandom_range(1, sb.pool);
        1, 2:    sz = $urandom_range(2048, 12000);
        default: sz = $urandom_range(1, 2047);
      endcase
      send_op(CMD_ALLOC, sz, $urandom);
    end else if (r < 90 && s >= 0) begin
      last_freed = sb.astart[s];
      send_op(CMD_FREE, size_for(sb.alen[s]), sb.astart[s]);
    end else begin
      // malformed requests
      case ($urandom_range(0, 4))
        0: send_op(1'($urandom_range(0, 1)), $urandom & 32'h1FFFFFF, $urandom & 32'hFFFFFF);
        1: send_op(CMD_FREE, size_for(256), last_freed);
        2: if (s >= 0) send_op(CMD_FREE, sb.alen[s] + 2048, sb.astart[s]);
           else send_op(CMD_FREE, 128, $urandom);
        3: send_op(1'($urandom_range(0, 1)), 0, $urandom);
        default: send_op(CMD_FREE, $urandom_range(1, 4096), $urandom_range(0, 4095) * 128);
      endcase
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] pools[7];
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    burst_left = 0;
    last_freed = 0;
    alloc_pct = 50;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // directed: rounding edges, error codes, offset zero
    send_op(CMD_ALLOC, 0, 0);
    send_op(CMD_ALLOC, 1, 0);
    send_op(CMD_ALLOC, 128, 0);
    send_op(CMD_ALLOC, 129, 0);
    send_op(CMD_ALLOC, 2047, 0);
    send_op(CMD_ALLOC, 2048, 0);
    send_op(CMD_ALLOC, 2049, 0);
    send_op(CMD_ALLOC, 25'h1FFFFFF, 24'hFFFFFF);
    send_op(CMD_ALLOC, 25'h1000000, 0);
    send_op(CMD_FREE, 0, 0);
    send_op(CMD_FREE, 128, 24'hFFFFFF);
    send_op(CMD_FREE, 128, 0);
    send_op(CMD_FREE, 4096, 0);
    send_op(CMD_FREE, 2048, 0);
    send_op(CMD_FREE, 2048, 0);
    send_op(CMD_ALLOC, POOL_RESET - 8192, 0);
    send_op(CMD_ALLOC, 8192, 0);
    send_op(CMD_FREE, POOL_RESET - 8192, 0);

    // fragment: fill the table, free every other block to fill the list
    write_pool(POOL_RESET);
    for (int k = 0; k < AT_DEPTH + 1; k++) send_op(CMD_ALLOC, 100, 0);
    quiesce();
    for (int k = 0; k < AT_DEPTH; k += 2) send_op(CMD_FREE, sb.astart[k], 0);
    quiesce();
    for (int k = 0; k < AT_DEPTH; k += 2) send_op(CMD_FREE, 128, sb.astart[k]);
    for (int k = 1; k < AT_DEPTH; k += 2) send_op(CMD_FREE, 128, sb.astart[k]);
    quiesce();
    for (int k = 0; k < AT_DEPTH; k++)
      if (sb.avalid[k]) send_op(CMD_FREE, 128, sb.astart[k]);

    // random phases across pool sizes, extremes included
    pools[0] = 25'd2048;
    pools[1] = 25'd0;
    pools[2] = 25'h1000000;
    pools[3] = 25'h1FFFFFF;
    pools[4] = POOL_RESET;
    pools[5] = SIZE_W'($urandom_range(2049, 65536));
    pools[6] = SIZE_W'($urandom & 32'h1FFFFFF);
    for (int p = 0; p < 7; p++) begin
      write_pool(pools[p]);
      for (int n = 0; n < 239; n++) begin
        alloc_pct = (n < 120) ? 70 : 40;
        random_request();
      end
    end

    quiesce();
    $display("run covered %0d requests, %0d results, %0d ok, over 8 pool settings",
             sent, sb.results, sb.ok_count);
    $display("status mix: zero %0d exceed %0d nofit %0d unknown %0d mismatch %0d",
             sb.status_seen[ST_ZERO], sb.status_seen[ST_EXCEED], sb.status_seen[ST_NOFIT],
             sb.status_seen[ST_UNKNOWN], sb.status_seen[ST_MISMATCH]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
